// ===== src/ffba_pkg.sv =====
`default_nettype none
package ffba_pkg;

  // Field widths
  localparam int ACT_W      = 2;
  localparam int SIZE_W     = 17;
  localparam int ADDR_W     = 16;
  localparam int OFF_W      = 17;
  localparam int LIMIT_W    = 17;
  localparam int HDR_W      = 13;
  localparam int UNITS_W    = 14;  // rounded request in 16-byte units
  localparam int BLK_W      = 12;  // block size field of a header
  localparam int MAX_IDX_W  = 12;  // header slot index at the largest arena

  // Arena geometry
  localparam int ARENA_BYTES_DEF = 65536;
  localparam int ALIGN           = 16;
  localparam int HDR_BYTES       = 16;
  localparam int ADDR_SPACE      = 65536;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC     = 2'd0,
    ACT_FREE      = 2'd1,
    ACT_TOP_RESET = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_DONE
  } state_t;

  // Header store access from the sequencer
  typedef struct packed {
    logic                 re;
    logic [MAX_IDX_W-1:0] raddr;
    logic                 we;
    logic [MAX_IDX_W-1:0] waddr;
    logic [HDR_W-1:0]     wdata;
  } hdr_req_t;

endpackage
`default_nettype wire

// ===== src/ffba_in_if.sv =====
`default_nettype none
interface ffba_in_if;
  import ffba_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACT_W-1:0]    action;
  logic [SIZE_W-1:0]   req_size;
  logic [ADDR_W-1:0]   addr;

  modport source (output valid, output action, output req_size, output addr,
                  input ready);
  modport sink   (input valid, input action, input req_size, input addr,
                  output ready);
endinterface
`default_nettype wire

// ===== src/ffba_out_if.sv =====
`default_nettype none
interface ffba_out_if;
  import ffba_pkg::*;

  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  result_addr;
  logic               status;

  modport source (output valid, output result_addr, output status, input ready);
  modport sink   (input valid, input result_addr, input status, output ready);
endinterface
`default_nettype wire

// ===== src/ffba_hdr_mem.sv =====
`default_nettype none
module ffba_hdr_mem #(
  parameter int DEPTH = 4096
) (
  input  wire logic                      clk,
  input  wire ffba_pkg::hdr_req_t        req,
  output      logic [ffba_pkg::HDR_W-1:0] rdata
);
  import ffba_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [HDR_W-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[IDX_W-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr[IDX_W-1:0]];
    end
  end

endmodule
`default_nettype wire

// ===== src/ffba_ctrl.sv =====
`default_nettype none
module ffba_ctrl #(
  parameter int ARENA_BYTES = ffba_pkg::ARENA_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ffba_pkg::LIMIT_W-1:0]  cfg_wr_data,
  ffba_in_if.sink                            in_ch,
  ffba_out_if.source                         out_ch,
  output      ffba_pkg::hdr_req_t            hdr_req,
  input  wire logic [ffba_pkg::HDR_W-1:0]    hdr_rdata
);
  import ffba_pkg::*;

  localparam int EFF_BYTES = (ARENA_BYTES < ADDR_SPACE) ? ARENA_BYTES : ADDR_SPACE;
  localparam logic [LIMIT_W-1:0] EFF_LIMIT = LIMIT_W'(EFF_BYTES);

  state_t              state_r, state_nxt;
  logic [LIMIT_W-1:0]  limit_r;
  logic [ACT_W-1:0]    action_r, action_nxt;
  logic [UNITS_W-1:0]  units_r, units_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [OFF_W-1:0]    cur_r, cur_nxt;
  logic [OFF_W-1:0]    top_r, top_nxt;
  logic [ADDR_W-1:0]   res_r, res_nxt;
  logic                status_r, status_nxt;

  logic [LIMIT_W-1:0]  lim_eff;
  logic [BLK_W-1:0]    h_units;
  logic [UNITS_W-1:0]  step_units;
  logic [OFF_W+1:0]    step_sum;
  logic [OFF_W:0]      cur_plus;
  logic [SIZE_W:0]     req_round;

  // Limit clamped to the arena
  assign lim_eff = (limit_r > EFF_LIMIT) ? EFF_LIMIT : limit_r;

  // Shared adder: end of the block at cur, from a header or the request
  assign h_units    = hdr_rdata[HDR_W-1:1];
  assign step_units = (state_r == ST_CHK) ? UNITS_W'(h_units) : units_r;
  assign step_sum   = (OFF_W+2)'(cur_r) + (OFF_W+2)'(HDR_BYTES)
                      + (OFF_W+2)'({step_units, 4'b0000});
  assign cur_plus   = (OFF_W+1)'(cur_r) + (OFF_W+1)'(HDR_BYTES);
  assign req_round  = (SIZE_W+1)'(in_ch.req_size) + (SIZE_W+1)'(ALIGN - 1);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      top_r   <= '0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    units_r  <= units_nxt;
    addr_r   <= addr_nxt;
    cur_r    <= cur_nxt;
    res_r    <= res_nxt;
    status_r <= status_nxt;
  end

  // Sequencer: one header per read/check pair
  always_comb begin
    state_nxt  = state_r;
    action_nxt = action_r;
    units_nxt  = units_r;
    addr_nxt   = addr_r;
    cur_nxt    = cur_r;
    top_nxt    = top_r;
    res_nxt    = res_r;
    status_nxt = status_r;
    hdr_req    = '0;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          action_nxt = in_ch.action;
          addr_nxt   = in_ch.addr;
          units_nxt  = UNITS_W'(req_round >> 4);
          cur_nxt    = '0;
          res_nxt    = '0;
          status_nxt = 1'b1;
          unique case (in_ch.action)
            ACT_ALLOC: begin
              state_nxt = ST_RD;
            end
            ACT_FREE: begin
              if (in_ch.addr >= ADDR_W'(HDR_BYTES) && OFF_W'(in_ch.addr) < top_r) begin
                state_nxt = ST_RD;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            ACT_TOP_RESET: begin
              if (limit_r != '0) begin
                top_nxt    = '0;
                status_nxt = 1'b0;
              end
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_RD: begin
        if (cur_r < top_r) begin
          hdr_req.re    = 1'b1;
          hdr_req.raddr = MAX_IDX_W'(cur_r >> 4);
          state_nxt     = ST_CHK;
        end else begin
          // End of list: append for an allocate if it fits, a free has missed
          if (action_r == ACT_ALLOC && step_sum <= (OFF_W+2)'(lim_eff)
              && cur_plus <= (OFF_W+1)'(ADDR_SPACE - 1)) begin
            hdr_req.we    = 1'b1;
            hdr_req.waddr = MAX_IDX_W'(cur_r >> 4);
            hdr_req.wdata = {units_r[BLK_W-1:0], 1'b1};
            res_nxt       = cur_plus[ADDR_W-1:0];
            top_nxt       = step_sum[OFF_W-1:0];
            status_nxt    = 1'b0;
          end
          state_nxt = ST_DONE;
        end
      end

      ST_CHK: begin
        if (action_r == ACT_ALLOC) begin
          if (!hdr_rdata[0] && UNITS_W'(h_units) >= units_r) begin
            hdr_req.we    = 1'b1;
            hdr_req.waddr = MAX_IDX_W'(cur_r >> 4);
            hdr_req.wdata = {h_units, 1'b1};
            res_nxt       = cur_plus[ADDR_W-1:0];
            status_nxt    = 1'b0;
            state_nxt     = ST_DONE;
          end else begin
            cur_nxt   = step_sum[OFF_W-1:0];
            state_nxt = ST_RD;
          end
        end else begin
          if (cur_plus == (OFF_W+1)'(addr_r)) begin
            if (hdr_rdata[0]) begin
              hdr_req.we    = 1'b1;
              hdr_req.waddr = MAX_IDX_W'(cur_r >> 4);
              hdr_req.wdata = {h_units, 1'b0};
              status_nxt    = 1'b0;
            end
            state_nxt = ST_DONE;
          end else if (cur_plus > (OFF_W+1)'(addr_r)) begin
            state_nxt = ST_DONE;
          end else begin
            cur_nxt   = step_sum[OFF_W-1:0];
            state_nxt = ST_RD;
          end
        end
      end

      ST_DONE: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.result_addr = res_r;
  assign out_ch.status      = status_r;

endmodule
`default_nettype wire

// ===== src/first_fit_block_allocator_top.sv =====
// First-fit allocator over an implicit list of 16-byte headers.
// Input channel in_ch carries an action (allocate, free, reset top),
// a request size in bytes and a payload offset to free. Each accepted
// transaction gives exactly one result transaction on out_ch: the payload
// offset of the allocated block (0 otherwise) and a status bit, 0 on success.
// cfg_wr_en/cfg_wr_data write the arena limit in bytes; 0 means uninitialised.
// The block walks the header list, one header per read/check pair
// (registered read of the header store, then check and step of the
// shared adder). One transaction is in flight at a time: in_ch is
// ready only while idle.
// The result is held in a register until out_ch is taken; a stalled receiver
// holds the block in that state and no new transaction is accepted.
// Reset sets the top pointer to 0 and the limit to 65536. The header store
// is not cleared: the walk only visits headers written since the top was
// last pulled back, so no clearing pass is needed.
`default_nettype none
module first_fit_block_allocator_top #(
  parameter int ARENA_BYTES = ffba_pkg::ARENA_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ffba_pkg::LIMIT_W-1:0]  cfg_wr_data,
  ffba_in_if.sink                            in_ch,
  ffba_out_if.source                         out_ch
);
  import ffba_pkg::*;

  localparam int EFF_BYTES = (ARENA_BYTES < ADDR_SPACE) ? ARENA_BYTES : ADDR_SPACE;
  localparam int HDR_SLOTS = EFF_BYTES / HDR_BYTES;

  hdr_req_t          hdr_req;
  logic [HDR_W-1:0]  hdr_rdata;

  ffba_ctrl #(
    .ARENA_BYTES (ARENA_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .hdr_req     (hdr_req),
    .hdr_rdata   (hdr_rdata)
  );

  ffba_hdr_mem #(
    .DEPTH (HDR_SLOTS)
  ) u_hdr_mem (
    .clk   (clk),
    .req   (hdr_req),
    .rdata (hdr_rdata)
  );

endmodule
`default_nettype wire
